// ===== rtl/dmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types, codes and helpers for the dual motor PWM direction drive.
// ----------------------------------------------------------------------------
package dmpd_pkg;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// Maneuver codes
	localparam logic [3:0] MAN_FWD    = 4'd0;
	localparam logic [3:0] MAN_BACK   = 4'd1;
	localparam logic [3:0] MAN_TURN_L = 4'd2;
	localparam logic [3:0] MAN_TURN_R = 4'd3;
	localparam logic [3:0] MAN_DRFT_L = 4'd4;
	localparam logic [3:0] MAN_DRFT_R = 4'd5;
	localparam logic [3:0] MAN_STOP   = 4'd6;
	localparam logic [3:0] MAN_BRAKE  = 4'd7;
	localparam logic [3:0] MAN_SET_L  = 4'd8;
	localparam logic [3:0] MAN_SET_R  = 4'd9;

	// Per-motor direction codes
	localparam logic [1:0] DIR_FWD  = 2'd0;
	localparam logic [1:0] DIR_BACK = 2'd1;
	localparam logic [1:0] DIR_LOCK = 2'd2;
	localparam logic [1:0] DIR_FREE = 2'd3;

	// Direction pin patterns, bit 0 is in1, bit 1 is in2
	localparam logic [1:0] PINS_FWD   = 2'b01;
	localparam logic [1:0] PINS_BACK  = 2'b10;
	localparam logic [1:0] PINS_BRAKE = 2'b11;
	localparam logic [1:0] PINS_COAST = 2'b00;

	localparam logic [7:0] DUTY_FULL = 8'd255;
	localparam logic [6:0] RATIO_RST = 7'd50;

	// floor(x / 100) for x < 43699 is (x * 5243) >> 19
	localparam int          PROD_W      = 15;
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic       req_type;
		logic [3:0] maneuver;
		logic [1:0] motor_dir;
		logic [7:0] speed;
	} req_t;

	typedef struct packed {
		logic left_pwm;
		logic right_pwm;
		logic left_in1;
		logic left_in2;
		logic right_in1;
		logic right_in2;
	} rsp_t;

	// Registered request plus the speed * ratio product
	typedef struct packed {
		logic                valid;
		req_t                req;
		logic [PROD_W-1:0]   prod;
	} stage_t;

	// One channel's drive setting
	typedef struct packed {
		logic [1:0] pins;
		logic [7:0] duty;
	} chan_t;

	function automatic chan_t drive(input logic [1:0] dir, input logic [7:0] spd);
		chan_t c;
		case (dir)
			DIR_FWD: begin
				c.pins = PINS_FWD;
				c.duty = spd;
			end
			DIR_BACK: begin
				c.pins = PINS_BACK;
				c.duty = spd;
			end
			DIR_LOCK: begin
				c.pins = PINS_BRAKE;
				c.duty = DUTY_FULL;
			end
			default: begin
				c.pins = PINS_COAST;
				c.duty = 8'd0;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/dual_motor_pwm_direction_drive.sv =====
// ----------------------------------------------------------------------------
// dual_motor_pwm_direction_drive
// Two-channel H-bridge driver: PWM ticks and motion commands in, six pin
// levels out per request.
//
//   channel | signals                         | payload
//   --------+---------------------------------+----------------------------
//   in      | in_valid / in_ready             | in_req  (req_t)
//   out     | out_valid / out_ready           | out_rsp (rsp_t)
//   cfg     | cfg_valid / cfg_ready           | cfg_data, turn ratio, 7 bits
//
// One request per cycle sustained while out_ready is high. An accepted request
// sits in the input register, then is decoded into the result register.
// The result register parts the two sides: a new request enters while a
// finished result waits, and the input stalls only when both stages are full.
// Reset clears the counter, duties and pins (coast) and loads ratio 50.
// Config writes are always accepted.
// ----------------------------------------------------------------------------
module dual_motor_pwm_direction_drive (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dmpd_pkg::req_t  in_req,
	output logic            out_valid,
	input  logic            out_ready,
	output dmpd_pkg::rsp_t  out_rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [6:0]      cfg_data
);

	logic [6:0]        ratio_q;
	logic              advance;
	dmpd_pkg::stage_t  st_s1;

	// Turn ratio register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= dmpd_pkg::RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			ratio_q <= cfg_data;
		end
	end

	dmpd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.ratio    (ratio_q),
		.advance  (advance),
		.st_s1    (st_s1)
	);

	dmpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.st_s1     (st_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

endmodule

// ===== rtl/dmpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// dmpd_in_stage
// Input register: captures a request and the speed times turn ratio product.
// ----------------------------------------------------------------------------
module dmpd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dmpd_pkg::req_t    in_req,
	input  logic [6:0]        ratio,
	input  logic              advance,
	output dmpd_pkg::stage_t  st_s1
);

	logic                        valid_s1;
	dmpd_pkg::req_t              req_s1;
	logic [dmpd_pkg::PROD_W-1:0] prod_s1;
	logic                        load;

	// Stage frees up when empty or when its request moves on
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, product taken ahead of the divide
	always_ff @(posedge clk) begin
		if (load) begin
			req_s1  <= in_req;
			prod_s1 <= dmpd_pkg::PROD_W'({7'd0, in_req.speed} * {8'd0, ratio});
		end
	end

	assign st_s1.valid = valid_s1;
	assign st_s1.req   = req_s1;
	assign st_s1.prod  = prod_s1;

endmodule

// ===== rtl/dmpd_core.sv =====
// ----------------------------------------------------------------------------
// dmpd_core
// Command decode, PWM counter and pin state, and the result register.
// ----------------------------------------------------------------------------
module dmpd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  dmpd_pkg::stage_t st_s1,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output dmpd_pkg::rsp_t   out_rsp
);

	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  lduty_q, lduty_n;
	logic [7:0]  rduty_q, rduty_n;
	logic [1:0]  lpins_q, lpins_n;
	logic [1:0]  rpins_q, rpins_n;
	logic [1:0]  pwm_q, pwm_n;
	logic        out_valid_q;
	dmpd_pkg::rsp_t rsp_q;

	logic [27:0]  recip;
	logic [8:0]   quot;
	logic [7:0]   inner;
	logic [7:0]   spd;
	dmpd_pkg::chan_t lc, rc;

	// Move on when the result register is free or being drained
	assign advance = st_s1.valid && (!out_valid_q || out_ready);

	// Inner wheel speed: divide product by 100, saturate
	assign recip = {13'd0, st_s1.prod} * {15'd0, dmpd_pkg::RECIP_100};
	assign quot  = recip[dmpd_pkg::RECIP_SHIFT +: 9];
	assign inner = (quot > 9'd255) ? dmpd_pkg::DUTY_FULL : quot[7:0];
	assign spd   = st_s1.req.speed;

	// Next state
	always_comb begin
		cnt_n   = cnt_q;
		pwm_n   = pwm_q;
		lc      = '{pins: lpins_q, duty: lduty_q};
		rc      = '{pins: rpins_q, duty: rduty_q};
		if (st_s1.req.req_type == dmpd_pkg::REQ_TICK) begin
			cnt_n = cnt_q + 8'd1;
			pwm_n = {cnt_n < rduty_q, cnt_n < lduty_q};
		end else begin
			case (st_s1.req.maneuver)
				dmpd_pkg::MAN_FWD: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
				end
				dmpd_pkg::MAN_BACK: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_BACK, spd);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_BACK, spd);
				end
				dmpd_pkg::MAN_TURN_L: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, inner);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
				end
				dmpd_pkg::MAN_TURN_R: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, inner);
				end
				dmpd_pkg::MAN_DRFT_L: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FREE, 8'd0);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
				end
				dmpd_pkg::MAN_DRFT_R: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FWD, spd);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FREE, 8'd0);
				end
				dmpd_pkg::MAN_STOP: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_FREE, 8'd0);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_FREE, 8'd0);
				end
				dmpd_pkg::MAN_BRAKE: begin
					lc = dmpd_pkg::drive(dmpd_pkg::DIR_LOCK, 8'd0);
					rc = dmpd_pkg::drive(dmpd_pkg::DIR_LOCK, 8'd0);
				end
				dmpd_pkg::MAN_SET_L: begin
					lc = dmpd_pkg::drive(st_s1.req.motor_dir, spd);
				end
				dmpd_pkg::MAN_SET_R: begin
					rc = dmpd_pkg::drive(st_s1.req.motor_dir, spd);
				end
				default: begin
					// unused codes leave state alone
				end
			endcase
		end
		lduty_n = lc.duty;
		lpins_n = lc.pins;
		rduty_n = rc.duty;
		rpins_n = rc.pins;
	end

	// Driver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 8'd0;
			lduty_q <= 8'd0;
			rduty_q <= 8'd0;
			lpins_q <= dmpd_pkg::PINS_COAST;
			rpins_q <= dmpd_pkg::PINS_COAST;
			pwm_q   <= 2'b00;
		end else if (advance) begin
			cnt_q   <= cnt_n;
			lduty_q <= lduty_n;
			rduty_q <= rduty_n;
			lpins_q <= lpins_n;
			rpins_q <= rpins_n;
			pwm_q   <= pwm_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= '{left_pwm: pwm_n[0], right_pwm: pwm_n[1],
				left_in1: lpins_n[0], left_in2: lpins_n[1],
				right_in1: rpins_n[0], right_in2: rpins_n[1]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;

`ifndef SYNTHESIS
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("request advanced without a result");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_s1.req.req_type == dmpd_pkg::REQ_TICK)
		|=> cnt_q == $past(cnt_q) + 8'd1)
		else $error("tick did not advance the PWM counter");

	a_cnt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q) && $stable(lduty_q) && $stable(rduty_q))
		else $error("driver state moved without a request");

	a_brake_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_s1.req.req_type == dmpd_pkg::REQ_CMD
			&& st_s1.req.maneuver == dmpd_pkg::MAN_BRAKE)
		|=> rsp_q.left_in1 && rsp_q.left_in2 && rsp_q.right_in1 && rsp_q.right_in2
			&& lduty_q == dmpd_pkg::DUTY_FULL && rduty_q == dmpd_pkg::DUTY_FULL)
		else $error("brake did not drive both bridges to full brake");
`endif

endmodule

// ===== tb/sv/dual_motor_pwm_direction_drive_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_motor_pwm_direction_drive_tb
// Self-checking bench for the two-channel H-bridge driver. A short table of
// hand-picked requests is followed by random phases, each run at its own turn
// ratio. Every accepted request is run through a behavioral copy of the
// driver, and the six pin levels it gives (or a fixed row's own answer)
// are matched against the block's results in order.
// ----------------------------------------------------------------------------
module dual_motor_pwm_direction_drive_tb;

	localparam int CYC_LIMIT    = 500_000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 4;
	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 6;

	// Maneuver codes with no meaning, the block must leave state alone
	localparam logic [3:0] MAN_SPARE_LO = 4'd10;
	localparam logic [3:0] MAN_SPARE_HI = 4'd15;

	// One channel's direction pins and duty
	typedef struct packed {
		logic [1:0] pins;
		logic [7:0] duty;
	} wheel_t;

	// One row of the directed table; fixed rows carry their own answer
	typedef struct {
		dmpd_pkg::req_t req;
		bit             fixed;
		dmpd_pkg::rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dmpd_pkg::req_t in_req;
	logic out_valid;
	logic out_ready;
	dmpd_pkg::rsp_t out_rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [6:0] cfg_data;

	// Behavioral driver state
	logic [6:0] turn_ratio;
	logic [7:0] pwm_count;
	logic [1:0] pwm_lvl;
	wheel_t     left_w;
	wheel_t     right_w;

	dmpd_pkg::rsp_t pins_due[$];
	row_t steps[$];
	int   bad_cnt = 0;
	int   cyc_cnt = 0;
	int   burst_left = 0;
	int   gap_max = 0;

	// Receiver stall control
	int          hold_ask = 0;
	int          hold_seen = 0;
	int          rx_hold = 0;
	logic [5:0]  rx_cyc = '0;
	logic [15:0] rx_pat = 16'hFFFF;

	string fld_name[6] = '{"left_pwm", "right_pwm", "left_in1", "left_in2",
		"right_in1", "right_in2"};

	dual_motor_pwm_direction_drive i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioral model
	// ------------------------------------------------------------------
	function automatic wheel_t wheel(input logic [1:0] dir, input logic [7:0] spd);
		wheel_t w;
		case (dir)
			dmpd_pkg::DIR_FWD:  w = '{dmpd_pkg::PINS_FWD, spd};
			dmpd_pkg::DIR_BACK: w = '{dmpd_pkg::PINS_BACK, spd};
			dmpd_pkg::DIR_LOCK: w = '{dmpd_pkg::PINS_BRAKE, dmpd_pkg::DUTY_FULL};
			default:            w = '{dmpd_pkg::PINS_COAST, 8'd0};
		endcase
		return w;
	endfunction

	// Inner wheel during a turn, floor of percent, clipped to full duty
	function automatic logic [7:0] inner_duty(input logic [7:0] spd);
		int q;
		q = int'(spd) * int'(turn_ratio) / 100;
		return (q > 255) ? dmpd_pkg::DUTY_FULL : q[7:0];
	endfunction

	// Apply one request to the model state and return the pin levels
	function automatic dmpd_pkg::rsp_t pins_after(input dmpd_pkg::req_t r);
		dmpd_pkg::rsp_t o;
		if (r.req_type == dmpd_pkg::REQ_TICK) begin
			pwm_count = pwm_count + 8'd1;
			pwm_lvl   = {pwm_count < right_w.duty, pwm_count < left_w.duty};
		end else begin
			case (r.maneuver)
				dmpd_pkg::MAN_FWD: begin
					left_w  = wheel(dmpd_pkg::DIR_FWD, r.speed);
					right_w = wheel(dmpd_pkg::DIR_FWD, r.speed);
				end
				dmpd_pkg::MAN_BACK: begin
					left_w  = wheel(dmpd_pkg::DIR_BACK, r.speed);
					right_w = wheel(dmpd_pkg::DIR_BACK, r.speed);
				end
				dmpd_pkg::MAN_TURN_L: begin
					left_w  = wheel(dmpd_pkg::DIR_FWD, inner_duty(r.speed));
					right_w = wheel(dmpd_pkg::DIR_FWD, r.speed);
				end
				dmpd_pkg::MAN_TURN_R: begin
					left_w  = wheel(dmpd_pkg::DIR_FWD, r.speed);
					right_w = wheel(dmpd_pkg::DIR_FWD, inner_duty(r.speed));
				end
				dmpd_pkg::MAN_DRFT_L: begin
					left_w  = wheel(dmpd_pkg::DIR_FREE, 8'd0);
					right_w = wheel(dmpd_pkg::DIR_FWD, r.speed);
				end
				dmpd_pkg::MAN_DRFT_R: begin
					left_w  = wheel(dmpd_pkg::DIR_FWD, r.speed);
					right_w = wheel(dmpd_pkg::DIR_FREE, 8'd0);
				end
				dmpd_pkg::MAN_STOP: begin
					left_w  = wheel(dmpd_pkg::DIR_FREE, 8'd0);
					right_w = wheel(dmpd_pkg::DIR_FREE, 8'd0);
				end
				dmpd_pkg::MAN_BRAKE: begin
					left_w  = wheel(dmpd_pkg::DIR_LOCK, 8'd0);
					right_w = wheel(dmpd_pkg::DIR_LOCK, 8'd0);
				end
				dmpd_pkg::MAN_SET_L: left_w  = wheel(r.motor_dir, r.speed);
				dmpd_pkg::MAN_SET_R: right_w = wheel(r.motor_dir, r.speed);
				default: ;
			endcase
		end
		o.left_pwm  = pwm_lvl[0];
		o.right_pwm = pwm_lvl[1];
		o.left_in1  = left_w.pins[0];
		o.left_in2  = left_w.pins[1];
		o.right_in1 = right_w.pins[0];
		o.right_in2 = right_w.pins[1];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic dmpd_pkg::req_t mk_req(input logic t, input logic [3:0] m,
		input logic [1:0] d, input logic [7:0] s);
		dmpd_pkg::req_t r;
		r.req_type  = t;
		r.maneuver  = m;
		r.motor_dir = d;
		r.speed     = s;
		return r;
	endfunction

	task automatic add_row(input dmpd_pkg::req_t r, input bit fixed,
		input dmpd_pkg::rsp_t rsp);
		row_t w;
		w.req   = r;
		w.fixed = fixed;
		w.rsp   = rsp;
		steps.push_back(w);
	endtask

	// Mostly ticks so the counter sweeps duties; commands keep unused fields noisy
	function automatic dmpd_pkg::req_t rand_req();
		dmpd_pkg::req_t r;
		r.req_type  = ($urandom_range(0, 9) < 3) ? dmpd_pkg::REQ_CMD : dmpd_pkg::REQ_TICK;
		if ($urandom_range(0, 9) == 0)
			r.maneuver = 4'($urandom_range(MAN_SPARE_LO, MAN_SPARE_HI));
		else
			r.maneuver = 4'($urandom_range(dmpd_pkg::MAN_FWD, dmpd_pkg::MAN_SET_R));
		r.motor_dir = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: r.speed = 8'd0;
			1: r.speed = 8'hFF;
			2: r.speed = 8'($urandom_range(0, 3));
			default: r.speed = 8'($urandom_range(0, 255));
		endcase
		return r;
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Offer one request, hold it until taken, then queue its pin levels
	task automatic offer(input dmpd_pkg::req_t r, input bit fixed,
		input dmpd_pkg::rsp_t rsp);
		dmpd_pkg::rsp_t p;
		if (gap_max != 0 && burst_left == 0) begin
			idle_cycles($urandom_range(1, gap_max));
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_req   <= r;
		do @(posedge clk); while (!in_ready);
		p = pins_after(r);
		pins_due.push_back(fixed ? rsp : p);
		if (burst_left > 0)
			burst_left--;
	endtask

	// Stop sending and wait until every queued result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pins_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_ratio(input logic [6:0] v);
		drain_results();
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		turn_ratio = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report(input string what);
		bad_cnt++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Receiver: rotating stall pattern, reloaded whenever rx_cyc wraps,
	// plus a long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		rx_cyc <= rx_cyc + 6'd1;
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			rx_hold   <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rx_pat[rx_cyc[3:0]];
		end
		if (rx_cyc == 6'd63) begin
			case ($urandom_range(0, 3))
				0: rx_pat <= 16'hFFFF;
				1: rx_pat <= 16'($urandom);
				2: rx_pat <= 16'($urandom & $urandom);
				default: rx_pat <= 16'($urandom | $urandom);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result check against the oldest expected pin set
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		dmpd_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pins_due.size() == 0) begin
				report($sformatf("result with no request pending: %b", out_rsp));
			end else begin
				want = pins_due.pop_front();
				for (int i = 0; i < 6; i++)
					if (out_rsp[5-i] !== want[5-i])
						report($sformatf("%s got %b want %b", fld_name[i],
							out_rsp[5-i], want[5-i]));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYC_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [6:0] ratios[NUM_PHASES];
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_req    = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;

		turn_ratio = dmpd_pkg::RATIO_RST;
		pwm_count  = '0;
		pwm_lvl    = '0;
		left_w     = '{dmpd_pkg::PINS_COAST, 8'd0};
		right_w    = '{dmpd_pkg::PINS_COAST, 8'd0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, run at the reset ratio
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 1, 6'b00_0000);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_BRAKE,
			dmpd_pkg::DIR_FWD, 8'h5A), 1, 6'b00_1111);
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 1, 6'b11_1111);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_STOP,
			dmpd_pkg::DIR_LOCK, 8'hFF), 1, 6'b11_0000);
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 1, 6'b00_0000);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_BACK,
			dmpd_pkg::DIR_FWD, 8'h00), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_TURN_L,
			dmpd_pkg::DIR_FWD, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_TICK, dmpd_pkg::MAN_FWD,
			dmpd_pkg::DIR_FWD, 8'h00), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_TURN_R,
			dmpd_pkg::DIR_FWD, 8'd200), 0, '0);
		// drift with a per-motor direction that must be ignored
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_DRFT_L,
			dmpd_pkg::DIR_FREE, 8'h80), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_DRFT_R,
			dmpd_pkg::DIR_LOCK, 8'h01), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_L,
			dmpd_pkg::DIR_FWD, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_L,
			dmpd_pkg::DIR_BACK, 8'h01), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_L,
			dmpd_pkg::DIR_LOCK, 8'h33), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_L,
			dmpd_pkg::DIR_FREE, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_R,
			dmpd_pkg::DIR_FWD, 8'h80), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_R,
			dmpd_pkg::DIR_BACK, 8'hFE), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_R,
			dmpd_pkg::DIR_LOCK, 8'h00), 0, '0);
		// tick with every unused field set
		add_row(mk_req(dmpd_pkg::REQ_TICK, MAN_SPARE_HI,
			dmpd_pkg::DIR_FREE, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, MAN_SPARE_LO,
			dmpd_pkg::DIR_BACK, 8'hAA), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, MAN_SPARE_HI,
			dmpd_pkg::DIR_FREE, 8'hFF), 0, '0);
		add_row(mk_req(dmpd_pkg::REQ_CMD, dmpd_pkg::MAN_SET_R,
			dmpd_pkg::DIR_FREE, 8'h12), 0, '0);

		gap_max = 4;
		foreach (steps[i])
			offer(steps[i].req, steps[i].fixed, steps[i].rsp);

		// Random phases, each at its own turn ratio
		ratios[0] = 7'd0;
		ratios[1] = 7'd127;
		ratios[2] = 7'd100;
		ratios[3] = 7'd1;
		ratios[4] = 7'($urandom_range(2, 99));
		ratios[5] = dmpd_pkg::RATIO_RST;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_ratio(ratios[ph]);
			gap_max    = (ph == 0 || ph == 2) ? 0 : $urandom_range(2, 8);
			burst_left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long receiver hold while requests keep coming
				if (ph == 2 && k == 100)
					hold_ask++;
				// sender waits for every result before carrying on
				if (ph == 3 && k == 125)
					drain_results();
				offer(rand_req(), 0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (bad_cnt == 0 && pins_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== dual_motor_pwm_direction_drive.f =====
rtl/dmpd_pkg.sv
rtl/dmpd_in_stage.sv
rtl/dmpd_core.sv
rtl/dual_motor_pwm_direction_drive.sv
tb/sv/dual_motor_pwm_direction_drive_tb.sv
